// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assertion macros shared by the rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// implication whose consequent is checked in the next cycle, outside reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/plcm_pkg.sv -----
// ---------------------------------------------------------------------------
// plcm_pkg
// shared widths, register indexes and pipeline types of the colour map
// ---------------------------------------------------------------------------
`default_nettype none

package plcm_pkg;

    // field widths
    localparam int LEVEL_W   = 16;
    localparam int COL_W     = 8;
    localparam int RGB_W     = 3 * COL_W;
    localparam int NODE_W    = LEVEL_W + RGB_W;
    localparam int CFG_IDX_W = 3;

    // node table
    localparam int NODE_REGS     = 7;
    localparam int MAX_NODES_DEF = 7;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 3'd7;
    localparam logic [CFG_IDX_W-1:0] NODE_COUNT_RST = 3'd7;
    localparam logic [CFG_IDX_W-1:0] NODE_COUNT_MIN = 3'd2;

    // divider sizing: numerator 2*mag*d + w, divisor 2*w, quotient below 256
    localparam int DIST_W    = LEVEL_W;
    localparam int NUM_W     = 2 * COL_W + LEVEL_W - COL_W + 1 + COL_W;
    localparam int DEN_W     = DIST_W + 1;
    localparam int DIV_STEPS = COL_W;

    // word moving through the divider stages
    typedef struct packed {
        logic                            is_const;
        logic [RGB_W-1:0]                left;
        logic [2:0]                      neg;
        logic [2:0][NUM_W-1:0]           rem;
        logic [2:0][COL_W-1:0]           quo;
        logic [DEN_W-1:0]                den;
    } t_div;

endpackage

`default_nettype wire

// ----- rtl/piecewise_linear_colour_map.sv -----
// ---------------------------------------------------------------------------
// piecewise_linear_colour_map
// maps a signed Q8.8 level to an RGB colour by linear interpolation over a
// table of up to seven programmable nodes
// ---------------------------------------------------------------------------
// usage:
//   input channel  i_in_valid / o_in_ready carries one level word (i_level)
//   output channel o_out_valid / i_out_ready carries one colour word
//   (o_red, o_green, o_blue) for every level word accepted
//   nodes and node count are written on the i_cfg_we port while no word is
//   in flight; node i sits at index i, the node count at index 7
// throughput: one word per clock while the output is not stalled; the bound is
//   the 13-stage pipeline, of which eight stages each resolve one quotient bit
//   of the three channel dividers
// reset: pipeline empties, nodes clear to zero, node count returns to seven
// stall: while o_out_valid waits on i_out_ready the whole pipeline holds and
//   o_in_ready drops; nothing is lost or repeated
// ---------------------------------------------------------------------------
`default_nettype none

module piecewise_linear_colour_map #(
    parameter int MAX_NODES = plcm_pkg::MAX_NODES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration
    input  logic                                 i_cfg_we,
    input  logic [plcm_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [plcm_pkg::NODE_W-1:0]          i_cfg_data,
    // level input
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [plcm_pkg::LEVEL_W-1:0]  i_level,
    // colour output
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [plcm_pkg::COL_W-1:0]           o_red,
    output logic [plcm_pkg::COL_W-1:0]           o_green,
    output logic [plcm_pkg::COL_W-1:0]           o_blue
);
    import plcm_pkg::*;

    localparam int                   NSTAGE = 4 + DIV_STEPS + 1;
    localparam int                   ST_DIV = 3;
    localparam logic [CFG_IDX_W-1:0] NMAX   = CFG_IDX_W'(MAX_NODES);

    // configuration registers
    logic [NODE_W-1:0]    r_node [MAX_NODES];
    logic [CFG_IDX_W-1:0] r_n_used;
    logic [CFG_IDX_W-1:0] n_n_used;

    // pipeline control
    logic [NSTAGE-1:0] r_vld;
    logic              en;

    // stage 1: compares
    logic signed [LEVEL_W-1:0] r1_level;
    logic [MAX_NODES-1:0]      r1_ge;
    logic [MAX_NODES-1:0]      r1_le;
    logic [MAX_NODES-1:0]      n1_ge;
    logic [MAX_NODES-1:0]      n1_le;

    // stage 2: segment select
    logic signed [LEVEL_W-1:0] r2_level;
    logic [MAX_NODES-1:0]      r2_lsel;
    logic [MAX_NODES-1:0]      r2_rsel;
    logic                      r2_const;
    logic [MAX_NODES-1:0]      n2_lsel;
    logic [MAX_NODES-1:0]      n2_rsel;
    logic                      n2_const;
    logic                      s2_found;

    // stage 3: distances and node colours
    logic signed [LEVEL_W-1:0] s3_pl;
    logic signed [LEVEL_W-1:0] s3_pr;
    logic [RGB_W-1:0]          s3_lcol;
    logic [RGB_W-1:0]          s3_rcol;
    logic signed [LEVEL_W:0]   s3_d;
    logic signed [LEVEL_W:0]   s3_w;
    logic [DIST_W-1:0]         r3_d;
    logic [DIST_W-1:0]         r3_w;
    logic [RGB_W-1:0]          r3_lcol;
    logic [RGB_W-1:0]          r3_rcol;
    logic                      r3_const;

    // stage 4 and divider steps
    t_div r_div [DIV_STEPS+1];
    t_div n_div [DIV_STEPS+1];

    // output stage
    logic [COL_W-1:0] r_red;
    logic [COL_W-1:0] r_green;
    logic [COL_W-1:0] r_blue;
    logic [2:0][COL_W-1:0] n_rgb;

    // whole pipeline advances when the output word is free or taken
    assign en          = !r_vld[NSTAGE-1] || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_vld[NSTAGE-1];
    assign o_red       = r_red;
    assign o_green     = r_green;
    assign o_blue      = r_blue;

    // node count clamped into 2..MAX_NODES at write time
    always_comb begin
        if (i_cfg_data[CFG_IDX_W-1:0] < NODE_COUNT_MIN) begin
            n_n_used = NODE_COUNT_MIN;
        end else if (i_cfg_data[CFG_IDX_W-1:0] > NMAX) begin
            n_n_used = NMAX;
        end else begin
            n_n_used = i_cfg_data[CFG_IDX_W-1:0];
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < MAX_NODES; j++) begin
                r_node[j] <= '0;
            end
            r_n_used <= (NODE_COUNT_RST > NMAX) ? NMAX : NODE_COUNT_RST;
        end else if (i_cfg_we) begin
            for (int j = 0; j < MAX_NODES; j++) begin
                if (i_cfg_idx == CFG_IDX_W'(j)) begin
                    r_node[j] <= i_cfg_data;
                end
            end
            if (i_cfg_idx == CFG_NODE_COUNT) begin
                r_n_used <= n_n_used;
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTAGE-2:0], i_in_valid};
        end
    end

    // stage 1: compare level against every node position
    always_comb begin
        for (int j = 0; j < MAX_NODES; j++) begin
            n1_ge[j] = i_level >= $signed(r_node[j][NODE_W-1:RGB_W]);
            n1_le[j] = i_level <= $signed(r_node[j][NODE_W-1:RGB_W]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_level <= i_level;
            r1_ge    <= n1_ge;
            r1_le    <= n1_le;
        end
    end

    // stage 2: first node if the level is below it, else first matching segment, else last used node
    always_comb begin
        s2_found = 1'b0;
        n2_lsel  = '0;
        n2_rsel  = '0;
        n2_const = 1'b0;
        for (int i = 0; i < MAX_NODES - 1; i++) begin
            if (!s2_found && (CFG_IDX_W'(i + 1) < r_n_used) && r1_ge[i] && r1_le[i+1]) begin
                n2_lsel[i]   = 1'b1;
                n2_rsel[i+1] = 1'b1;
                s2_found     = 1'b1;
            end
        end
        if (!r1_ge[0]) begin
            n2_lsel  = MAX_NODES'(1);
            n2_rsel  = MAX_NODES'(1);
            n2_const = 1'b1;
        end else if (!s2_found) begin
            for (int j = 0; j < MAX_NODES; j++) begin
                n2_lsel[j] = (CFG_IDX_W'(j) == (r_n_used - CFG_IDX_W'(1)));
            end
            n2_rsel  = n2_lsel;
            n2_const = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_level <= r1_level;
            r2_lsel  <= n2_lsel;
            r2_rsel  <= n2_rsel;
            r2_const <= n2_const;
        end
    end

    // stage 3: fetch both nodes, offset into segment and segment width
    always_comb begin
        s3_pl   = '0;
        s3_pr   = '0;
        s3_lcol = '0;
        s3_rcol = '0;
        for (int j = 0; j < MAX_NODES; j++) begin
            if (r2_lsel[j]) begin
                s3_pl   |= r_node[j][NODE_W-1:RGB_W];
                s3_lcol |= r_node[j][RGB_W-1:0];
            end
            if (r2_rsel[j]) begin
                s3_pr   |= r_node[j][NODE_W-1:RGB_W];
                s3_rcol |= r_node[j][RGB_W-1:0];
            end
        end
        s3_d = {r2_level[LEVEL_W-1], r2_level} - {s3_pl[LEVEL_W-1], s3_pl};
        s3_w = {s3_pr[LEVEL_W-1], s3_pr} - {s3_pl[LEVEL_W-1], s3_pl};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_d     <= s3_d[DIST_W-1:0];
            r3_w     <= s3_w[DIST_W-1:0];
            r3_lcol  <= s3_lcol;
            r3_rcol  <= s3_rcol;
            r3_const <= r2_const || (s3_w == '0);
        end
    end

    // stage 4: per channel |diff|, sign and rounding numerator 2*|diff|*d + w
    always_comb begin
        logic signed [COL_W:0]  diff;
        logic [COL_W-1:0]       mag;
        logic [NUM_W-2:0]       prod;
        n_div[0].is_const = r3_const;
        n_div[0].left     = r3_lcol;
        n_div[0].den      = {r3_w, 1'b0};
        n_div[0].quo      = '0;
        for (int c = 0; c < 3; c++) begin
            diff = $signed({1'b0, r3_rcol[RGB_W-1-COL_W*c -: COL_W]})
                 - $signed({1'b0, r3_lcol[RGB_W-1-COL_W*c -: COL_W]});
            mag  = diff[COL_W] ? COL_W'(-diff) : diff[COL_W-1:0];
            prod = (NUM_W-1)'(mag) * (NUM_W-1)'(r3_d);
            n_div[0].neg[c] = diff[COL_W];
            n_div[0].rem[c] = {prod, 1'b0} + NUM_W'(r3_w);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_div[0] <= n_div[0];
        end
    end

    // divider: one quotient bit per stage, msb first
    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
        localparam int K = DIV_STEPS - 1 - s;

        always_comb begin
            logic [NUM_W-1:0] trial;
            n_div[s+1] = r_div[s];
            trial      = NUM_W'(r_div[s].den) << K;
            for (int c = 0; c < 3; c++) begin
                if (r_div[s].rem[c] >= trial) begin
                    n_div[s+1].rem[c]    = r_div[s].rem[c] - trial;
                    n_div[s+1].quo[c][K] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_div[s+1] <= n_div[s+1];
            end
        end
    end

    // final: left colour plus or minus the rounded offset, saturated; constant words keep the left colour
    always_comb begin
        logic signed [COL_W+1:0] sum;
        logic [COL_W-1:0]        a;
        for (int c = 0; c < 3; c++) begin
            a   = r_div[DIV_STEPS].left[RGB_W-1-COL_W*c -: COL_W];
            sum = r_div[DIV_STEPS].neg[c]
                ? $signed({2'b00, a}) - $signed({2'b00, r_div[DIV_STEPS].quo[c]})
                : $signed({2'b00, a}) + $signed({2'b00, r_div[DIV_STEPS].quo[c]});
            if (r_div[DIV_STEPS].is_const) begin
                n_rgb[c] = a;
            end else if (sum < 0) begin
                n_rgb[c] = '0;
            end else if (sum > $signed((COL_W+2)'(2**COL_W - 1))) begin
                n_rgb[c] = '1;
            end else begin
                n_rgb[c] = sum[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_red   <= n_rgb[0];
            r_green <= n_rgb[1];
            r_blue  <= n_rgb[2];
        end
    end

    // checks
    `include "assert_macros.svh"

    `ASSERT_ALWAYS(a_n_used_range, (r_n_used >= NODE_COUNT_MIN) && (r_n_used <= NMAX), "node count out of range")
    `ASSERT_NEXT(a_accept_enters, i_in_valid && o_in_ready, r_vld[0], "accepted word missing in first stage")
    `ASSERT_NEXT(a_stall_holds, o_out_valid && !i_out_ready, $stable(r_vld), "pipeline moved during stall")
    `ASSERT_NEXT(a_div_feeds, en && r_vld[ST_DIV-1], r_vld[ST_DIV], "word lost entering divider")

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for piecewise_linear_colour_map: every accepted level
// word is predicted against a mirror of the node table and each colour word
// is compared in order, while both channels idle and stall at random
// ---------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import plcm_pkg::*;

    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 30;
    localparam int RANDOM_TABLES = 12;
    localparam int TABLE_LEVELS  = 120;

    typedef struct packed {
        logic [COL_W-1:0] red;
        logic [COL_W-1:0] green;
        logic [COL_W-1:0] blue;
    } t_colour;

    typedef logic [NODE_W-1:0] t_node_set [NODE_REGS];

    // dut ports; the driven inputs are known from time zero
    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_idx   = '0;
    logic [NODE_W-1:0]          i_cfg_data  = '0;
    logic                       i_in_valid  = 1'b0;
    logic                       o_in_ready;
    logic signed [LEVEL_W-1:0]  i_level     = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic [COL_W-1:0]           o_red;
    logic [COL_W-1:0]           o_green;
    logic [COL_W-1:0]           o_blue;

    // mirror of the node registers
    logic [NODE_W-1:0]          node_tab [NODE_REGS];
    logic [2:0]                 node_cnt;

    t_colour                    expected_colours [$];
    int                         levels_accepted = 0;
    int                         colours_checked = 0;
    int                         tables_loaded   = 0;
    int                         mismatches      = 0;
    int                         idle_cycles     = 0;
    int                         out_hold        = 0;
    bit                         in_gaps_on      = 1'b1;
    bit                         out_stalls_on   = 1'b1;

    piecewise_linear_colour_map dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_level     (i_level),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_red       (o_red),
        .o_green     (o_green),
        .o_blue      (o_blue)
    );

    always #2 i_clk = ~i_clk;

    // ---------------------------------------------------------------------
    // helpers
    // ---------------------------------------------------------------------
    function automatic int node_pos(logic [NODE_W-1:0] nd);
        return int'($signed(nd[NODE_W-1:RGB_W]));
    endfunction

    function automatic logic [NODE_W-1:0] make_node(int pos, logic [RGB_W-1:0] rgb);
        logic [LEVEL_W-1:0] p;
        p = pos[LEVEL_W-1:0];
        return {p, rgb};
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        return ($urandom_range(0, 9) == 0) ? int'($urandom_range(8, 40))
                                           : int'($urandom_range(1, 3));
    endfunction

    // colour expected for one level against the mirrored table
    function automatic t_colour predict_colour(logic signed [LEVEL_W-1:0] lvl);
        int n, pl, pr, w, a, b, diff, mag, q, v;
        logic [RGB_W-1:0] rgb;
        n = int'(node_cnt);
        if (n < int'(NODE_COUNT_MIN)) n = int'(NODE_COUNT_MIN);
        if (n > MAX_NODES_DEF) n = MAX_NODES_DEF;
        if (int'(lvl) < node_pos(node_tab[0]))
            return t_colour'(node_tab[0][RGB_W-1:0]);
        for (int i = 0; i + 1 < n; i++) begin
            pl = node_pos(node_tab[i]);
            pr = node_pos(node_tab[i+1]);
            if (pl <= int'(lvl) && int'(lvl) <= pr) begin
                w = pr - pl;
                // zero-width segment keeps the left colour
                if (w == 0)
                    return t_colour'(node_tab[i][RGB_W-1:0]);
                for (int ch = 0; ch < 3; ch++) begin
                    a    = int'(node_tab[i][ch*COL_W +: COL_W]);
                    b    = int'(node_tab[i+1][ch*COL_W +: COL_W]);
                    diff = b - a;
                    mag  = (diff < 0) ? -diff : diff;
                    // round to nearest, ties away from zero
                    q    = (2 * mag * (int'(lvl) - pl) + w) / (2 * w);
                    v    = (diff < 0) ? a - q : a + q;
                    rgb[ch*COL_W +: COL_W] = (v < 0) ? 8'd0 : ((v > 255) ? 8'd255 : v[7:0]);
                end
                return t_colour'(rgb);
            end
        end
        return t_colour'(node_tab[n-1][RGB_W-1:0]);
    endfunction

    task automatic report_field(string name, logic [COL_W-1:0] want, logic [COL_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // ---------------------------------------------------------------------
    // prediction at the input handshake, checking at the output handshake
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin : scoreboard
        t_colour want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                expected_colours.push_back(predict_colour(i_level));
                levels_accepted++;
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_colours.size() == 0) begin
                    $display("%0t: colour word with no level pending, got %0d %0d %0d",
                             $time, o_red, o_green, o_blue);
                    mismatches++;
                end else begin
                    want = expected_colours.pop_front();
                    report_field("red", want.red, o_red);
                    report_field("green", want.green, o_green);
                    report_field("blue", want.blue, o_blue);
                    colours_checked++;
                end
            end
        end
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, run stopped", $time, IDLE_LIMIT);
            $display("piecewise_linear_colour_map verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // output back-pressure
    always @(negedge i_clk) begin
        if (!out_stalls_on) begin
            i_out_ready <= 1'b1;
        end else if (out_hold > 0) begin
            i_out_ready <= 1'b0;
            out_hold--;
        end else if ($urandom_range(0, 3) == 0) begin
            i_out_ready <= 1'b0;
            out_hold = pick_gap() - 1;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------------
    // drivers, all entered and left at a falling edge
    // ---------------------------------------------------------------------
    task automatic send_level(input int lvl);
        int gap, target;
        gap = (in_gaps_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_level    <= lvl[LEVEL_W-1:0];
        target = levels_accepted + 1;
        while (levels_accepted < target) @(negedge i_clk);
    endtask

    // hold the sender until every colour word has come back
    task automatic wait_for_colours();
        i_in_valid <= 1'b0;
        while (expected_colours.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [NODE_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        @(negedge i_clk);
        if (idx == CFG_NODE_COUNT) node_cnt = data[2:0];
        else node_tab[idx] = data;
    endtask

    task automatic load_table(input t_node_set nodes, input logic [NODE_W-1:0] count_word);
        wait_for_colours();
        for (int i = 0; i < NODE_REGS; i++) write_reg(i[CFG_IDX_W-1:0], nodes[i]);
        write_reg(CFG_NODE_COUNT, count_word);
        tables_loaded++;
    endtask

    // ---------------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------------

    // table straight out of reset: all nodes zero, seven in use
    task automatic test_cleared_table();
        int pts [5] = '{-32768, -1, 0, 1, 32767};
        foreach (pts[i]) send_level(pts[i]);
    endtask

    // full-range table with a zero-width first segment, rounding ties,
    // both channel directions and the extreme levels
    task automatic test_interpolation_points();
        t_node_set tab;
        int pts [15] = '{-32768, -32767, -1, 0, 1, 2, 3, 128, 255, 256,
                         600, 999, 1000, 32766, 32767};
        tab[0] = make_node(-32768, 24'hFF_00_80);
        tab[1] = make_node(-32768, 24'h00_FF_7F);
        tab[2] = make_node(0,      24'h0A_14_1E);
        tab[3] = make_node(2,      24'h0B_13_1E);
        tab[4] = make_node(256,    24'hFF_00_FF);
        tab[5] = make_node(1000,   24'h00_FF_00);
        tab[6] = make_node(32767,  24'h80_80_80);
        load_table(tab, 40'd7);
        foreach (pts[i]) send_level(pts[i]);
    endtask

    // unordered positions, level below the first node, no segment matching,
    // and node counts below the minimum
    task automatic test_table_special_cases();
        t_node_set tab;
        int pts3 [6] = '{0, 75, 100, 150, 200, 300};
        tab[0] = make_node(100, 24'h10_20_30);
        tab[1] = make_node(50,  24'hF0_E0_D0);
        tab[2] = make_node(200, 24'h00_FF_55);
        tab[3] = make_node(300, 24'hFF_00_AA);
        tab[4] = make_node(400, 24'h12_34_56);
        tab[5] = make_node(500, 24'h65_43_21);
        tab[6] = make_node(600, 24'hFF_FF_FF);
        load_table(tab, 40'd3);
        foreach (pts3[i]) send_level(pts3[i]);
        load_table(tab, {37'h15_5555_5555, 3'd0});
        send_level(40);
        send_level(100);
        load_table(tab, {37'h0A_AAAA_AAAA, 3'd1});
        send_level(300);
        load_table(tab, 40'd7);
        send_level(250);
    endtask

    // random tables in four shapes, random levels aimed at the segments
    task automatic test_random_tables();
        int counts [RANDOM_TABLES] = '{7, 2, 5, 0, 7, 3, 1, 6, 4, 7, 2, 7};
        t_node_set tab;
        logic [NODE_W-1:0] cnt_word;
        logic [RGB_W-1:0] rgb;
        int p [NODE_REGS];
        int style, centre, tmp, n, k, lo, hi, lvl, seg;
        for (int t = 0; t < RANDOM_TABLES; t++) begin
            style = t % 4;
            centre = int'($urandom_range(0, 60000)) - 30000;
            foreach (p[i]) begin
                if (style == 1) p[i] = centre + int'($urandom_range(0, 3000)) - 1500;
                else p[i] = int'($urandom_range(0, 65535)) - 32768;
            end
            // every shape but the unordered one is sorted
            if (style != 3) begin
                for (int i = 0; i < NODE_REGS; i++)
                    for (int j = 0; j + 1 < NODE_REGS - i; j++)
                        if (p[j] > p[j+1]) begin
                            tmp = p[j]; p[j] = p[j+1]; p[j+1] = tmp;
                        end
            end
            if (style == 2) begin
                for (int i = 1; i < NODE_REGS; i++)
                    if ($urandom_range(0, 2) == 0) p[i] = p[i-1];
            end
            if (style == 0 && t % 8 == 0) begin
                p[0] = -32768;
                p[NODE_REGS-1] = 32767;
            end
            foreach (tab[i]) begin
                rgb = RGB_W'($urandom());
                for (int ch = 0; ch < 3; ch++)
                    if ($urandom_range(0, 3) == 0)
                        rgb[ch*COL_W +: COL_W] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                tab[i] = make_node(p[i], rgb);
            end
            cnt_word = NODE_W'({$urandom(), $urandom()});
            cnt_word[2:0] = counts[t][2:0];
            load_table(tab, cnt_word);

            // vary idling: some tables run with none at all
            in_gaps_on    = !(t == 0 || t == 5 || t == 9);
            out_stalls_on = !(t == 0 || t == 5 || t == 10);

            n = (counts[t] < 2) ? 2 : counts[t];
            for (int m = 0; m < TABLE_LEVELS; m++) begin
                k = $urandom_range(0, 9);
                if (k < 2) begin
                    lvl = int'($urandom_range(0, 65535)) - 32768;
                end else if (k == 2) begin
                    lvl = node_pos(node_tab[$urandom_range(0, n - 1)]);
                end else if (k == 3) begin
                    lvl = node_pos(node_tab[$urandom_range(0, n - 1)])
                          + int'($urandom_range(0, 2)) - 1;
                end else begin
                    seg = $urandom_range(0, n - 2);
                    lo  = node_pos(node_tab[seg]);
                    hi  = node_pos(node_tab[seg+1]);
                    if (lo > hi) begin
                        tmp = lo; lo = hi; hi = tmp;
                    end
                    lvl = lo + int'($urandom_range(0, hi - lo));
                end
                if (lvl < -32768) lvl = -32768;
                if (lvl > 32767) lvl = 32767;
                send_level(lvl);
                // pause mid-table until the pipeline has emptied
                if (t == 2 && m == TABLE_LEVELS / 2) wait_for_colours();
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------------
    initial begin
        foreach (node_tab[i]) node_tab[i] = '0;
        node_cnt = NODE_COUNT_RST;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_cleared_table();
        test_interpolation_points();
        test_table_special_cases();
        test_random_tables();

        wait_for_colours();
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("covered %0d level words over %0d node tables, node counts 0..7,",
                 levels_accepted, tables_loaded);
        $display("sorted, clustered, repeated and unordered positions; %0d colours checked",
                 colours_checked);
        if (mismatches == 0 && expected_colours.size() == 0) begin
            $display("piecewise_linear_colour_map verification clean");
        end else begin
            $display("piecewise_linear_colour_map verification failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/plcm_pkg.sv
rtl/piecewise_linear_colour_map.sv
tb/sv/tb_top.sv
